[sv/ttl_pkg.sv]
package ttl_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LINE_BITS_DEF   = 24;
    localparam int MAX_TOKENS      = 4;

    localparam logic [3:0] K_LBRACE = 4'd0;
    localparam logic [3:0] K_RBRACE = 4'd1;
    localparam logic [3:0] K_LBRACK = 4'd2;
    localparam logic [3:0] K_RBRACK = 4'd3;
    localparam logic [3:0] K_COMMA  = 4'd4;
    localparam logic [3:0] K_COLON  = 4'd5;
    localparam logic [3:0] K_SEMI   = 4'd6;
    localparam logic [3:0] K_LESSEQ = 4'd7;
    localparam logic [3:0] K_NUMBER = 4'd8;
    localparam logic [3:0] K_IDENT  = 4'd9;
    localparam logic [3:0] K_STRING = 4'd10;
    localparam logic [3:0] K_DOT    = 4'd11;
    localparam logic [3:0] K_ERROR  = 4'd12;
    localparam logic [3:0] K_EOF    = 4'd13;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_SLASH   = 4'd1;
    localparam logic [3:0] M_COMMENT = 4'd2;
    localparam logic [3:0] M_LESS    = 4'd3;
    localparam logic [3:0] M_SIGN    = 4'd4;
    localparam logic [3:0] M_DOT     = 4'd5;
    localparam logic [3:0] M_INT     = 4'd6;
    localparam logic [3:0] M_FRAC    = 4'd7;
    localparam logic [3:0] M_EXP0    = 4'd8;
    localparam logic [3:0] M_EXP1    = 4'd9;
    localparam logic [3:0] M_WORD    = 4'd10;
    localparam logic [3:0] M_STRING  = 4'd11;

    // one token as it leaves the lexer core, fields already clamped
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] offset;
        logic [31:0] length;
        logic [23:0] line;
        logic [31:0] column;
        logic        last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
    endfunction

    // progress: 1..8 into "infinity", 9..11 into "nan"
    function automatic logic [3:0] kw_first(input logic [7:0] b);
        logic [7:0] l;
        l = to_lower(b);
        return (l == 8'h69) ? 4'd1 : ((l == 8'h6e) ? 4'd9 : 4'd0);
    endfunction

    function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] b);
        logic [7:0] l;
        logic [7:0] want;
        l = to_lower(b);
        unique case (p)
            4'd1: want = 8'h6e;
            4'd2: want = 8'h66;
            4'd3: want = 8'h69;
            4'd4: want = 8'h6e;
            4'd5: want = 8'h69;
            4'd6: want = 8'h74;
            4'd7: want = 8'h79;
            4'd9: want = 8'h61;
            4'd10: want = 8'h6e;
            default: want = 8'h00;
        endcase
        return (want != 8'h00 && l == want) ? p + 4'd1 : 4'd0;
    endfunction

endpackage

[sv/ttl_front.sv]
module ttl_front #(
    parameter int OFFSET_BITS = ttl_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = ttl_pkg::LINE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               char_code,
    input  logic                     char_present,
    input  logic                     end_of_source,
    output logic                     grp_valid,
    output logic [2:0]               grp_count,
    output ttl_pkg::token_t [3:0]    grp_tok,
    input  logic                     grp_ready
);
    import ttl_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_CAP  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_CAP = '1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);

    logic [3:0]             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] lstart_reg, lstart_next;
    logic [OFFSET_BITS-1:0] tso_reg, tso_next;
    logic [LINE_BITS-1:0]   tsl_reg, tsl_next;
    logic [OFFSET_BITS-1:0] tsc_reg, tsc_next;
    logic [3:0]             kw_reg, kw_next_v;
    logic                   held_reg, held_next;

    // one spare slot beyond the four group slots; only the first four tokens leave
    logic             fire;
    token_t [4:0]     toks;
    logic [2:0]       cnt;
    logic [2:0]       cnt_cap;

    assign in_ready  = grp_ready;
    assign fire      = in_valid && in_ready;
    assign grp_valid = fire && (cnt != 3'd0);
    assign grp_count = cnt_cap;
    assign grp_tok   = toks[3:0];

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_CAP) ? v : v + OFF_ONE;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] dif(input logic [OFFSET_BITS-1:0] a,
                                                   input logic [OFFSET_BITS-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic logic [31:0] clo(input logic [OFFSET_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [23:0] cll(input logic [LINE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'hFF_FFFF) ? 24'hFF_FFFF : w[23:0];
    endfunction

    // lexer step, mirrors the stepwise classification of one byte
    always_comb
    begin
        logic [7:0]             b;
        logic [OFFSET_BITS-1:0] off;
        logic                   do_close;
        logic                   do_idle;
        logic                   term_dot;
        logic                   is_eof_close;
        logic [OFFSET_BITS-1:0] s;
        logic [OFFSET_BITS-1:0] col_off;
        logic [OFFSET_BITS-1:0] end_off;
        int                     pass;
        b           = char_code;
        off         = pos_reg;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        lstart_next = lstart_reg;
        tso_next    = tso_reg;
        tsl_next    = tsl_reg;
        tsc_next    = tsc_reg;
        kw_next_v   = kw_reg;
        held_next   = held_reg;
        toks        = '0;
        cnt         = 3'd0;
        do_close    = 1'b0;
        do_idle     = 1'b0;
        term_dot    = (b == 8'h2e);
        is_eof_close = 1'b0;
        s           = '0;
        col_off     = '0;
        end_off     = off;

        for (pass = 0; pass < 2; pass++)
        begin
            do_close = 1'b0;
            do_idle  = 1'b0;
            if (pass == 0 && char_present)
            begin
                end_off = off;
                unique case (mode_next)
                    M_SLASH:   if (b == 8'h2f) mode_next = M_COMMENT; else do_close = 1'b1;
                    M_COMMENT: if (b == 8'h0a) do_close = 1'b1;
                    M_LESS:
                        if (b == 8'h3d)
                        begin
                            toks[cnt] = '{K_LESSEQ, clo(tso_next), 32'd2, cll(tsl_next),
                                          clo(tsc_next), 1'b0};
                            cnt = cnt + 3'd1;
                            mode_next = M_IDLE;
                        end
                        else do_close = 1'b1;
                    M_SIGN:
                        if (is_digit(b))
                        begin
                            mode_next = M_INT;
                            held_next = 1'b0;
                        end
                        else if (b == 8'h2e) mode_next = M_DOT;
                        else if (is_alpha(b) && kw_first(b) != 4'd0)
                        begin
                            mode_next = M_WORD;
                            kw_next_v = kw_first(b);
                        end
                        else do_close = 1'b1;
                    M_DOT:
                        if (is_digit(b))
                        begin
                            mode_next = M_FRAC;
                            held_next = 1'b0;
                        end
                        else do_close = 1'b1;
                    M_INT:
                        if (is_digit(b)) ;
                        else if (b == 8'h2e) mode_next = M_FRAC;
                        else if (b == 8'h65 || b == 8'h45) mode_next = M_EXP0;
                        else do_close = 1'b1;
                    M_FRAC:
                        if (is_digit(b)) ;
                        else if (b == 8'h65 || b == 8'h45) mode_next = M_EXP0;
                        else do_close = 1'b1;
                    M_EXP0:
                        if (is_digit(b) || b == 8'h2b || b == 8'h2d) mode_next = M_EXP1;
                        else do_close = 1'b1;
                    M_EXP1:
                        if (!is_digit(b)) do_close = 1'b1;
                    M_WORD:
                        if (is_alpha(b) || is_digit(b))
                        begin
                            kw_next_v = kw_next(kw_next_v, b);
                            if (held_next && kw_next_v == 4'd0)
                            begin
                                toks[cnt] = '{K_ERROR, clo(tso_next), 32'd1, cll(tsl_next),
                                              clo(tsc_next), 1'b0};
                                cnt = cnt + 3'd1;
                                tso_next = sat_inc(tso_next);
                                tsc_next = sat_inc(tsc_next);
                                held_next = 1'b0;
                            end
                        end
                        else do_close = 1'b1;
                    M_STRING:
                        if (b == 8'h22)
                        begin
                            s = sat_inc(tso_next);
                            toks[cnt] = '{K_STRING, clo(s), clo(dif(off, s)), cll(tsl_next),
                                          clo(tsc_next), 1'b0};
                            cnt = cnt + 3'd1;
                            mode_next = M_IDLE;
                        end
                        else if (b == 8'h0a)
                        begin
                            if (line_next != LINE_CAP) line_next = line_next + LINE_ONE;
                            lstart_next = sat_inc(off);
                        end
                    default: do_idle = 1'b1;
                endcase
                if (do_close) do_idle = 1'b1;
            end
            else if (pass == 1 && end_of_source)
            begin
                do_close     = 1'b1;
                is_eof_close = 1'b1;
                term_dot     = 1'b0;
                end_off      = pos_next;
            end

            // close pending token
            if (do_close)
            begin
                s = tso_next;
                unique case (mode_next)
                    M_SLASH, M_LESS, M_SIGN:
                    begin
                        toks[cnt] = '{K_ERROR, clo(s), 32'd1, cll(tsl_next), clo(tsc_next), 1'b0};
                        cnt = cnt + 3'd1;
                    end
                    M_DOT:
                    begin
                        if (held_next)
                        begin
                            toks[cnt] = '{K_ERROR, clo(tso_next), 32'd1, cll(tsl_next),
                                          clo(tsc_next), 1'b0};
                            cnt = cnt + 3'd1;
                            tso_next = sat_inc(tso_next);
                            tsc_next = sat_inc(tsc_next);
                        end
                        toks[cnt] = '{K_DOT, clo(tso_next), 32'd1, cll(tsl_next),
                                      clo(tsc_next), 1'b0};
                        cnt = cnt + 3'd1;
                    end
                    M_INT, M_FRAC, M_EXP0, M_EXP1:
                    begin
                        toks[cnt] = '{K_NUMBER, clo(s), clo(dif(end_off, s)), cll(tsl_next),
                                      clo(tsc_next), 1'b0};
                        cnt = cnt + 3'd1;
                    end
                    M_WORD:
                        if ((kw_next_v == 4'd3 || kw_next_v == 4'd8 || kw_next_v == 4'd11)
                            && !term_dot)
                        begin
                            toks[cnt] = '{K_NUMBER, clo(s), clo(dif(end_off, s)),
                                          cll(tsl_next), clo(tsc_next), 1'b0};
                            cnt = cnt + 3'd1;
                        end
                        else
                        begin
                            if (held_next)
                            begin
                                toks[cnt] = '{K_ERROR, clo(tso_next), 32'd1, cll(tsl_next),
                                              clo(tsc_next), 1'b0};
                                cnt = cnt + 3'd1;
                                tso_next = sat_inc(tso_next);
                                tsc_next = sat_inc(tsc_next);
                            end
                            toks[cnt] = '{K_IDENT, clo(tso_next),
                                          clo(dif(end_off, tso_next)), cll(tsl_next),
                                          clo(tsc_next), 1'b0};
                            cnt = cnt + 3'd1;
                        end
                    M_STRING:
                    begin
                        s = sat_inc(s);
                        toks[cnt] = '{K_ERROR, clo(s), clo(dif(end_off, s)), cll(tsl_next),
                                      clo(tsc_next), 1'b0};
                        cnt = cnt + 3'd1;
                    end
                    default: ;
                endcase
                mode_next = M_IDLE;
                held_next = 1'b0;
                kw_next_v = 4'd0;
            end

            // byte seen between tokens
            if (do_idle)
            begin
                col_off = (dif(off, lstart_next) == OFF_CAP) ? OFF_CAP
                        : dif(off, lstart_next) + OFF_ONE;
                if (b == 8'h7b || b == 8'h7d || b == 8'h5b || b == 8'h5d || b == 8'h2c
                    || b == 8'h3a || b == 8'h3b)
                begin
                    toks[cnt].kind   = (b == 8'h7b) ? K_LBRACE : (b == 8'h7d) ? K_RBRACE
                                     : (b == 8'h5b) ? K_LBRACK : (b == 8'h5d) ? K_RBRACK
                                     : (b == 8'h2c) ? K_COMMA : (b == 8'h3a) ? K_COLON
                                     : K_SEMI;
                    toks[cnt].offset = clo(off);
                    toks[cnt].length = 32'd1;
                    toks[cnt].line   = cll(line_next);
                    toks[cnt].column = clo(col_off);
                    cnt = cnt + 3'd1;
                end
                else if (b == 8'h20 || b == 8'h09 || b == 8'h0d) ;
                else if (b == 8'h0a)
                begin
                    if (line_next != LINE_CAP) line_next = line_next + LINE_ONE;
                    lstart_next = sat_inc(off);
                end
                else
                begin
                    tso_next = off;
                    tsl_next = line_next;
                    tsc_next = col_off;
                    if (b == 8'h2f) mode_next = M_SLASH;
                    else if (b == 8'h3c) mode_next = M_LESS;
                    else if (b == 8'h2b || b == 8'h2d)
                    begin
                        mode_next = M_SIGN;
                        held_next = 1'b1;
                    end
                    else if (is_digit(b)) mode_next = M_INT;
                    else if (b == 8'h2e) mode_next = M_DOT;
                    else if (is_alpha(b))
                    begin
                        mode_next = M_WORD;
                        kw_next_v = kw_first(b);
                    end
                    else if (b == 8'h22) mode_next = M_STRING;
                    else
                    begin
                        toks[cnt] = '{K_ERROR, clo(off), 32'd1, cll(line_next),
                                      clo(tsc_next), 1'b0};
                        cnt = cnt + 3'd1;
                    end
                end
            end

            if (pass == 0 && char_present) pos_next = sat_inc(pos_reg);

            if (is_eof_close)
            begin
                col_off = (dif(pos_next, lstart_next) == OFF_CAP) ? OFF_CAP
                        : dif(pos_next, lstart_next) + OFF_ONE;
                toks[cnt] = '{K_EOF, clo(pos_next), 32'd0, cll(line_next),
                              clo(col_off), 1'b0};
                cnt = cnt + 3'd1;
                mode_next   = M_IDLE;
                pos_next    = '0;
                line_next   = LINE_ONE;
                lstart_next = '0;
                tso_next    = '0;
                tsl_next    = LINE_ONE;
                tsc_next    = OFF_ONE;
                kw_next_v   = 4'd0;
                held_next   = 1'b0;
            end
        end
        // tokens past the fourth are dropped
        cnt_cap = (cnt > 3'd4) ? 3'd4 : cnt;
        if (cnt_cap != 3'd0) toks[cnt_cap - 3'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= LINE_ONE;
            lstart_reg <= '0;
            tso_reg    <= '0;
            tsl_reg    <= LINE_ONE;
            tsc_reg    <= OFF_ONE;
            kw_reg     <= 4'd0;
            held_reg   <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            lstart_reg <= lstart_next;
            tso_reg    <= tso_next;
            tsl_reg    <= tsl_next;
            tsc_reg    <= tsc_next;
            kw_reg     <= kw_next_v;
            held_reg   <= held_next;
        end
    end

endmodule

[sv/ttl_queue.sv]
module ttl_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  grp_valid,
    input  logic [2:0]            grp_count,
    input  ttl_pkg::token_t [3:0] grp_tok,
    output logic                  grp_ready,
    output logic                  out_valid,
    output ttl_pkg::token_t       out_tok,
    input  logic                  out_ready
);
    import ttl_pkg::*;

    // token FIFO, 8 deep; a whole group of up to four enters at once
    token_t     mem_reg [8];
    logic [2:0] wr_reg, wr_next;
    logic [2:0] rd_reg, rd_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       pop;
    logic       push;

    assign grp_ready = cnt_reg <= 4'd4;
    assign push      = grp_valid && grp_ready;
    assign out_valid = cnt_reg != 4'd0;
    assign out_tok   = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = push ? wr_reg + grp_count : wr_reg;
        rd_next  = pop ? rd_reg + 3'd1 : rd_reg;
        cnt_next = cnt_reg + (push ? {1'b0, grp_count} : 4'd0) - (pop ? 4'd1 : 4'd0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (push && 3'(i) < grp_count) mem_reg[3'(wr_reg + 3'(i))] <= grp_tok[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 3'd0;
            rd_reg  <= 3'd0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[sv/text_token_lexer_top.sv]
// Streaming lexer: one source byte per input item.
// Input channel: in_valid/in_ready with char_code, char_present, end_of_source.
// An item with end_of_source set flushes the pending token, adds end-of-file
// and returns the lexer to its start state for the next source.
// Output channel: out_valid/out_ready, one token per item, last_of_run set on
// the final token caused by an input item (up to four per input item).
// Throughput: one input item per cycle while the 8-entry token queue has room
// for four more; output drains one token per cycle while out_ready is high.
// Output order: a token is written to the token queue when the byte deciding
// it is accepted, and leaves it behind any tokens still queued.
// Stall: when the receiver holds out_ready low the queue fills and in_ready
// drops once fewer than four free entries remain.
// Reset: asynchronous, clears the queue and the lexer state (line 1, offset 0).
module text_token_lexer_top #(
    parameter int OFFSET_BITS = ttl_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = ttl_pkg::LINE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        char_present,
    input  logic        end_of_source,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [31:0] token_offset,
    output logic [31:0] token_length,
    output logic [23:0] token_line,
    output logic [31:0] token_column,
    output logic        last_of_run
);
    import ttl_pkg::*;

    logic         grp_valid;
    logic         grp_ready;
    logic [2:0]   grp_count;
    token_t [3:0] grp_tok;
    token_t       out_tok;

    ttl_front #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .char_code, .char_present, .end_of_source,
        .grp_valid, .grp_count, .grp_tok, .grp_ready
    );

    ttl_queue u_queue (
        .clk, .rst_n, .grp_valid, .grp_count, .grp_tok, .grp_ready,
        .out_valid, .out_tok, .out_ready
    );

    assign token_kind   = out_tok.kind;
    assign token_offset = out_tok.offset;
    assign token_length = out_tok.length;
    assign token_line   = out_tok.line;
    assign token_column = out_tok.column;
    assign last_of_run  = out_tok.last;

endmodule

[sv/ttl_checker.sv]
module ttl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  token_kind,
    input logic [31:0] token_length,
    input logic [23:0] token_line,
    input logic [31:0] token_column,
    input logic        last_of_run
);
    import ttl_pkg::*;

    // stalled token kind holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("token changed while stalled");

    // end-of-file closes a run and has no text
    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_EOF |-> last_of_run && token_length == 32'd0)
        else $error("bad end-of-file token");

    // line and column are one-based
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_line != 24'd0 && token_column != 32'd0)
        else $error("zero line or column");

    // less-equal is two bytes
    a_le: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_LESSEQ |-> token_length == 32'd2)
        else $error("bad less-equal length");
endmodule

bind text_token_lexer_top ttl_checker u_checker (
    .clk, .rst_n, .out_valid, .out_ready, .token_kind, .token_length,
    .token_line, .token_column, .last_of_run
);

[test/tb.sv]
module tb;
    import ttl_pkg::*;

    localparam logic [63:0] OFF_CAP  = 64'hFFFF_FFFF;
    localparam logic [63:0] LINE_CAP = 64'h00FF_FFFF;
    localparam string PUNCT    = "{}[],:;";
    localparam string INF_WORD = "infinity";
    localparam string NAN_WORD = "nan";

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        char_present;
    logic        end_of_source;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  token_kind;
    logic [31:0] token_offset;
    logic [31:0] token_length;
    logic [23:0] token_line;
    logic [31:0] token_column;
    logic        last_of_run;

    text_token_lexer_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .char_present(char_present),
        .end_of_source(end_of_source),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .token_offset(token_offset),
        .token_length(token_length), .token_line(token_line),
        .token_column(token_column), .last_of_run(last_of_run)
    );

    // directed stimulus row; fixed rows carry their one typed-in token
    typedef struct {
        logic [7:0] c;
        logic       p;
        logic       e;
        logic       fixed;
        token_t     tok;
    } lex_row_t;

    lex_row_t    rows[$];
    token_t      pending_tokens[$];
    token_t      step_tokens[$];
    logic [7:0]  text_bytes[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_ticket = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    logic        row_fixed;
    token_t      row_tok;

    // lexer shadow state
    logic [3:0]  lx_mode;
    logic [63:0] lx_pos, lx_line, lx_lstart, lx_toff, lx_tline, lx_tcol;
    logic [3:0]  lx_kw;
    logic        lx_sign;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic digit_b(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic letter_b(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    // keyword progress: 1..8 into infinity, 9..11 into nan
    function automatic logic [3:0] word_start(input logic [7:0] b);
        logic [7:0] l;
        l = fold_case(b);
        return l == "i" ? 4'd1 : (l == "n" ? 4'd9 : 4'd0);
    endfunction

    function automatic logic [3:0] word_advance(input logic [3:0] p, input logic [7:0] b);
        logic [7:0] l;
        l = fold_case(b);
        if (p >= 1 && p <= 7 && l == INF_WORD[p]) return p + 4'd1;
        if ((p == 9 || p == 10) && l == NAN_WORD[p - 8]) return p + 4'd1;
        return 4'd0;
    endfunction

    function automatic logic word_done(input logic [3:0] p);
        return p == 3 || p == 8 || p == 11;
    endfunction

    function automatic logic [63:0] sat_up(input logic [63:0] v);
        return v < OFF_CAP ? v + 64'd1 : OFF_CAP;
    endfunction

    function automatic logic [63:0] sub0(input logic [63:0] a, input logic [63:0] b);
        return a >= b ? a - b : 64'd0;
    endfunction

    function automatic logic [63:0] column_of(input logic [63:0] off);
        logic [63:0] d;
        d = sub0(off, lx_lstart);
        return d < OFF_CAP ? d + 64'd1 : OFF_CAP;
    endfunction

    function automatic token_t make_tok(input logic [3:0] k, input logic [63:0] off,
                                        input logic [63:0] len, input logic [63:0] line,
                                        input logic [63:0] col);
        token_t t;
        t.kind   = k;
        t.offset = off > OFF_CAP ? OFF_CAP[31:0] : off[31:0];
        t.length = len > OFF_CAP ? OFF_CAP[31:0] : len[31:0];
        t.line   = line > LINE_CAP ? LINE_CAP[23:0] : line[23:0];
        t.column = col > OFF_CAP ? OFF_CAP[31:0] : col[31:0];
        t.last   = 1'b0;
        return t;
    endfunction

    // append one byte to the random text
    task automatic add_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endtask

    task automatic put_tok(input logic [3:0] k, input logic [63:0] off, input logic [63:0] len,
                           input logic [63:0] line, input logic [63:0] col);
        if (step_tokens.size() < MAX_TOKENS)
            step_tokens.insert(step_tokens.size(), make_tok(k, off, len, line, col));
    endtask

    task automatic clear_lexer();
        lx_mode = M_IDLE;
        lx_pos = 0; lx_line = 1; lx_lstart = 0;
        lx_toff = 0; lx_tline = 1; lx_tcol = 1;
        lx_kw = 0; lx_sign = 0;
    endtask

    // held sign turns into an error, token moves past it
    task automatic flush_sign();
        put_tok(K_ERROR, lx_toff, 1, lx_tline, lx_tcol);
        lx_toff = sat_up(lx_toff);
        lx_tcol = sat_up(lx_tcol);
        lx_sign = 0;
    endtask

    // close the open token; dot_next tells if a '.' terminates it
    task automatic close_open(input logic [63:0] end_off, input logic dot_next);
        logic [63:0] s;
        s = lx_toff;
        case (lx_mode)
            M_SLASH, M_LESS, M_SIGN: put_tok(K_ERROR, s, 1, lx_tline, lx_tcol);
            M_DOT:
            begin
                if (lx_sign) flush_sign();
                put_tok(K_DOT, lx_toff, 1, lx_tline, lx_tcol);
            end
            M_INT, M_FRAC, M_EXP0, M_EXP1:
                put_tok(K_NUMBER, s, sub0(end_off, s), lx_tline, lx_tcol);
            M_WORD:
            begin
                if (word_done(lx_kw) && !dot_next)
                    put_tok(K_NUMBER, s, sub0(end_off, s), lx_tline, lx_tcol);
                else
                begin
                    if (lx_sign) flush_sign();
                    put_tok(K_IDENT, lx_toff, sub0(end_off, lx_toff), lx_tline, lx_tcol);
                end
            end
            M_STRING:
            begin
                s = sat_up(s);
                put_tok(K_ERROR, s, sub0(end_off, s), lx_tline, lx_tcol);
            end
            default: ;
        endcase
        lx_mode = M_IDLE;
        lx_sign = 0;
        lx_kw = 0;
    endtask

    task automatic start_byte(input logic [7:0] b, input logic [63:0] off);
        for (int k = 0; k < 7; k++)
        begin
            if (b == PUNCT[k])
            begin
                put_tok(K_LBRACE + 4'(k), off, 1, lx_line, column_of(off));
                return;
            end
        end
        if (b == " " || b == 8'h09 || b == 8'h0d) return;
        if (b == 8'h0a)
        begin
            if (lx_line < LINE_CAP) lx_line++;
            lx_lstart = sat_up(off);
            return;
        end
        lx_toff = off; lx_tline = lx_line; lx_tcol = column_of(off);
        if (b == "/") lx_mode = M_SLASH;
        else if (b == "<") lx_mode = M_LESS;
        else if (b == "+" || b == "-") begin lx_mode = M_SIGN; lx_sign = 1; end
        else if (digit_b(b)) lx_mode = M_INT;
        else if (b == ".") lx_mode = M_DOT;
        else if (letter_b(b)) begin lx_mode = M_WORD; lx_kw = word_start(b); end
        else if (b == 8'h22) lx_mode = M_STRING;
        else put_tok(K_ERROR, off, 1, lx_line, lx_tcol);
    endtask

    // one source byte; returns early where the open token simply grows
    task automatic lex_byte(input logic [7:0] b, input logic [63:0] off);
        logic [63:0] s;
        case (lx_mode)
            M_SLASH:   if (b == "/") begin lx_mode = M_COMMENT; return; end
            M_COMMENT: if (b != 8'h0a) return;
            M_LESS:
                if (b == "=")
                begin
                    put_tok(K_LESSEQ, lx_toff, 2, lx_tline, lx_tcol);
                    lx_mode = M_IDLE;
                    return;
                end
            M_SIGN:
            begin
                if (digit_b(b)) begin lx_mode = M_INT; lx_sign = 0; return; end
                if (b == ".") begin lx_mode = M_DOT; return; end
                if (letter_b(b) && word_start(b) != 0)
                begin
                    lx_mode = M_WORD; lx_kw = word_start(b);
                    return;
                end
            end
            M_DOT:  if (digit_b(b)) begin lx_mode = M_FRAC; lx_sign = 0; return; end
            M_INT:
            begin
                if (digit_b(b)) return;
                if (b == ".") begin lx_mode = M_FRAC; return; end
                if (b == "e" || b == "E") begin lx_mode = M_EXP0; return; end
            end
            M_FRAC:
            begin
                if (digit_b(b)) return;
                if (b == "e" || b == "E") begin lx_mode = M_EXP0; return; end
            end
            M_EXP0:
                if (digit_b(b) || b == "+" || b == "-") begin lx_mode = M_EXP1; return; end
            M_EXP1: if (digit_b(b)) return;
            M_WORD:
                if (letter_b(b) || digit_b(b))
                begin
                    lx_kw = word_advance(lx_kw, b);
                    if (lx_sign && lx_kw == 0) flush_sign();
                    return;
                end
            M_STRING:
            begin
                if (b == 8'h22)
                begin
                    s = sat_up(lx_toff);
                    put_tok(K_STRING, s, sub0(off, s), lx_tline, lx_tcol);
                    lx_mode = M_IDLE;
                end
                else if (b == 8'h0a)
                begin
                    if (lx_line < LINE_CAP) lx_line++;
                    lx_lstart = sat_up(off);
                end
                return;
            end
            default:
            begin
                start_byte(b, off);
                return;
            end
        endcase
        close_open(off, b == ".");
        start_byte(b, off);
    endtask

    // predict the tokens of one accepted item and queue them
    task automatic predict_tokens(input logic [7:0] c, input logic p, input logic e);
        step_tokens.delete();
        if (p)
        begin
            lex_byte(c, lx_pos);
            lx_pos = sat_up(lx_pos);
        end
        if (e)
        begin
            close_open(lx_pos, 1'b0);
            put_tok(K_EOF, lx_pos, 0, lx_line, column_of(lx_pos));
            clear_lexer();
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
    endtask

    // input monitor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_tokens(char_code, char_present, end_of_source);
            if (row_fixed && step_tokens.size() == 1)
                pending_tokens[pending_tokens.size() - 1] = row_tok;
        end
    end

    // output checker
    always @(posedge clk)
    begin
        token_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("token with nothing expected: kind %0d offset %0d", token_kind,
                       token_offset);
                errors++;
            end
            else
            begin
                w = pending_tokens.pop_front();
                if (token_kind !== w.kind)
                begin
                    $error("token_kind expected %0d got %0d", w.kind, token_kind);
                    errors++;
                end
                if (token_offset !== w.offset)
                begin
                    $error("token_offset expected %0d got %0d", w.offset, token_offset);
                    errors++;
                end
                if (token_length !== w.length)
                begin
                    $error("token_length expected %0d got %0d", w.length, token_length);
                    errors++;
                end
                if (token_line !== w.line)
                begin
                    $error("token_line expected %0d got %0d", w.line, token_line);
                    errors++;
                end
                if (token_column !== w.column)
                begin
                    $error("token_column expected %0d got %0d", w.column, token_column);
                    errors++;
                end
                if (last_of_run !== w.last)
                begin
                    $error("last_of_run expected %0d got %0d", w.last, last_of_run);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_ticket)
        begin
            hold_served = hold_ticket;
            hold_left = 120;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= $urandom_range(99) >= recv_stall_pct;
    end

    task automatic send_item(input logic [7:0] c, input logic p, input logic e,
                             input logic fixed, input token_t tok);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        char_present <= p;
        end_of_source <= e;
        row_fixed <= fixed;
        row_tok <= tok;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic add_row(input logic [7:0] c, input logic p, input logic e,
                           input logic fixed, input token_t tok);
        lex_row_t r;
        r.c = c; r.p = p; r.e = e; r.fixed = fixed; r.tok = tok;
        rows.insert(rows.size(), r);
    endtask

    task automatic add_text(input string s, input logic e_on_last);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], 1'b1, e_on_last && i == s.len() - 1, 1'b0, '0);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // random letter case for keyword text
    function automatic string mixed_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if ($urandom_range(1)) r[i] = r[i] - 8'd32;
        return r;
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] b;
        b = 8'(97 + $urandom_range(25));
        if ($urandom_range(3) == 0) b = "_";
        else if ($urandom_range(1)) b = b - 8'd32;
        return b;
    endfunction

    // append one well-formed fragment (or a bit of noise) to the byte queue
    task automatic make_fragment();
        string kw[3];
        kw[0] = "inf"; kw[1] = "nan"; kw[2] = "infinity";
        case ($urandom_range(13))
            0: add_byte(PUNCT[$urandom_range(6)]);
            1:
            begin
                if ($urandom_range(1)) add_byte($urandom_range(1) ? "+" : "-");
                repeat ($urandom_range(1, 4)) add_byte(8'(48 + $urandom_range(9)));
                if ($urandom_range(1))
                begin
                    add_byte(".");
                    repeat ($urandom_range(3)) add_byte(8'(48 + $urandom_range(9)));
                end
                if ($urandom_range(2) == 0)
                begin
                    add_byte($urandom_range(1) ? "e" : "E");
                    if ($urandom_range(1)) add_byte($urandom_range(1) ? "+" : "-");
                    repeat ($urandom_range(2)) add_byte(8'(48 + $urandom_range(9)));
                end
            end
            2:
            begin
                if ($urandom_range(1)) add_byte($urandom_range(1) ? "+" : "-");
                push_str(mixed_case(kw[$urandom_range(2)]));
                if ($urandom_range(2) == 0) add_byte(any_letter());
                if ($urandom_range(3) == 0) add_byte(".");
            end
            3:
            begin
                add_byte(any_letter());
                repeat ($urandom_range(4))
                    add_byte($urandom_range(2) ? any_letter() : 8'(48 + $urandom_range(9)));
            end
            4:
            begin
                add_byte(8'h22);
                repeat ($urandom_range(5))
                    case ($urandom_range(5))
                        0: add_byte(8'h0a);
                        1: add_byte(8'($urandom_range(255)) & 8'hdd);
                        default: add_byte(any_letter());
                    endcase
                if ($urandom_range(7) != 0) add_byte(8'h22);
            end
            5:
            begin
                push_str("//");
                repeat ($urandom_range(4)) add_byte(8'($urandom_range(255)));
                add_byte(8'h0a);
            end
            6: push_str("<=");
            7: add_byte(8'h0a);
            8: add_byte($urandom_range(1) ? 8'h09 : 8'h0d);
            9: add_byte(".");
            10: add_byte($urandom_range(2) == 0 ? "/" : "<");
            11: add_byte(8'($urandom_range(255)));
            default: add_byte(" ");
        endcase
    endtask

    // random traffic for one phase
    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        logic [7:0] b;
        int n;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        n = 0;
        while (n < count)
        begin
            if (text_bytes.size() == 0) make_fragment();
            if ($urandom_range(19) == 0)
            begin
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
                continue;
            end
            b = text_bytes.pop_front();
            n++;
            if ($urandom_range(29) == 0)
            begin
                if ($urandom_range(1))
                    send_item(b, 1'b1, 1'b1, 1'b0, '0);
                else
                begin
                    send_item(b, 1'b1, 1'b0, 1'b0, '0);
                    send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
                end
                text_bytes.delete();
            end
            else
                send_item(b, 1'b1, 1'b0, 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = 8'h00;
        char_present = 1'b0;
        end_of_source = 1'b0;
        out_ready = 1'b0;
        row_fixed = 1'b0;
        row_tok = '0;
        clear_lexer();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // punctuation and byte extremes right after reset, then a bare end
        add_row("{", 1, 0, 1, '{K_LBRACE, 32'd0, 32'd1, 24'd1, 32'd1, 1'b1});
        add_row("}", 1, 0, 1, '{K_RBRACE, 32'd1, 32'd1, 24'd1, 32'd2, 1'b1});
        add_row(8'h00, 1, 0, 1, '{K_ERROR, 32'd2, 32'd1, 24'd1, 32'd3, 1'b1});
        add_row(8'hFF, 1, 0, 1, '{K_ERROR, 32'd3, 32'd1, 24'd1, 32'd4, 1'b1});
        add_row(8'h00, 0, 1, 1, '{K_EOF, 32'd4, 32'd0, 24'd1, 32'd5, 1'b1});
        // signed word cut by a dot, multi-line string, less-equal, comment
        add_text("-InF.", 0);
        add_row(8'hA5, 0, 0, 0, '0);
        add_text("\"a\n\"<=//x\n", 0);
        // exponent number, then a string left open at the end of source
        add_text("+1e-\"", 1);
        foreach (rows[i]) send_item(rows[i].c, rows[i].p, rows[i].e, rows[i].fixed, rows[i].tok);

        run_phase(60, 0, 0);
        run_phase(60, 51, 0);
        run_phase(60, 0, 51);
        run_phase(60, 25, 25);
        // receiver holds off while the sender keeps pushing
        hold_ticket++;
        run_phase(70, 0, 0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0, '0);
        in_valid <= 1'b0;
        row_fixed <= 1'b0;
        recv_stall_pct = 0;

        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_tokens.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
sv/ttl_pkg.sv
sv/ttl_front.sv
sv/ttl_queue.sv
sv/text_token_lexer_top.sv
sv/ttl_checker.sv
test/tb.sv
